// File: rtl/core/irpd_pkg.sv
package irpd_pkg;

  localparam int unsigned TICK_W = 8;
  localparam int unsigned BITS_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MARK_TICKS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPACE_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CARRIER      = 3'd4;

  localparam logic [TICK_W-1:0] MARK_TICKS_RST        = 8'd10;
  localparam logic [TICK_W-1:0] START_SPACE_TICKS_RST = 8'd30;
  localparam logic [TICK_W-1:0] ONE_SPACE_TICKS_RST   = 8'd20;
  localparam logic [TICK_W-1:0] ZERO_SPACE_TICKS_RST  = 8'd10;
  localparam logic              IDLE_CARRIER_RST      = 1'b1;

  localparam logic [BITS_W-1:0] FRAME_BITS = 4'd8;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SEND = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  byte_value;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] mark_ticks;
    logic [TICK_W-1:0] start_space_ticks;
    logic [TICK_W-1:0] one_space_ticks;
    logic [TICK_W-1:0] zero_space_ticks;
    logic              idle_carrier;
  } cfg_t;

endpackage

// File: rtl/core/irpd_front.sv
module irpd_front
  import irpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_byte_value,
  output logic       q_valid,
  input  logic       q_pop,
  output cmd_t       q_cmd
);

  logic [1:0] count_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  cmd_t       mem_r [2];
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.byte_value = in_byte_value;
    unique case (in_action)
      1'b1:    cmd_in.kind = CMD_SEND;
      default: cmd_in.kind = CMD_TICK;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, q_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: rtl/core/irpd_back.sv
module irpd_back
  import irpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic out_carrier_on,
  output logic out_busy_res,
  output logic out_frame_done,
  output logic out_request_dropped
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_MARK,
    PH_START_GAP,
    PH_BIT_MARK,
    PH_BIT_GAP,
    PH_STOP_MARK1,
    PH_STOP_GAP,
    PH_STOP_MARK2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [TICK_W-1:0] seg_len;
  logic [TICK_W-1:0] tick_inc;
  logic              done;
  logic              dropped;
  logic              carrier;

  logic out_valid_r;
  logic out_carrier_on_r;
  logic out_busy_res_r;
  logic out_frame_done_r;
  logic out_request_dropped_r;

  // Take the next beat whenever the output slot is empty or being drained.
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    unique case (phase_r)
      PH_START_GAP, PH_STOP_GAP: seg_len = cfg.start_space_ticks;
      PH_BIT_GAP:                seg_len = shift_r[7] ? cfg.one_space_ticks
                                                      : cfg.zero_space_ticks;
      default:                   seg_len = cfg.mark_ticks;
    endcase
  end

  assign tick_inc = tick_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    done      = 1'b0;
    dropped   = 1'b0;
    if (q_cmd.kind == CMD_SEND) begin
      if (phase_r != PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        phase_nxt = PH_START_MARK;
        tick_nxt  = '0;
        shift_nxt = q_cmd.byte_value;
        bits_nxt  = FRAME_BITS;
      end
    end else if (phase_r != PH_IDLE) begin
      if (tick_inc == seg_len) begin
        tick_nxt = '0;
        unique case (phase_r)
          PH_START_MARK: phase_nxt = PH_START_GAP;
          PH_START_GAP:  phase_nxt = PH_BIT_MARK;
          PH_BIT_MARK:   phase_nxt = PH_BIT_GAP;
          PH_BIT_GAP: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bits_nxt  = bits_r - 4'd1;
            phase_nxt = (bits_r == 4'd1) ? PH_STOP_MARK1 : PH_BIT_MARK;
          end
          PH_STOP_MARK1: phase_nxt = PH_STOP_GAP;
          PH_STOP_GAP:   phase_nxt = PH_STOP_MARK2;
          default: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end else begin
        tick_nxt = tick_inc;
      end
    end
  end

  always_comb begin
    unique case (phase_nxt)
      PH_IDLE:                                carrier = cfg.idle_carrier;
      PH_START_GAP, PH_BIT_GAP, PH_STOP_GAP:  carrier = 1'b0;
      default:                                carrier = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      shift_r     <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        shift_r <= shift_nxt;
        bits_r  <= bits_nxt;
      end
      out_valid_r <= q_pop || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_carrier_on_r      <= carrier;
      out_busy_res_r        <= (phase_nxt != PH_IDLE);
      out_frame_done_r      <= done;
      out_request_dropped_r <= dropped;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_carrier_on      = out_carrier_on_r;
  assign out_busy_res        = out_busy_res_r;
  assign out_frame_done      = out_frame_done_r;
  assign out_request_dropped = out_request_dropped_r;

`ifndef SYNTH
  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_done_r |-> !out_busy_res_r)
    else $error("frame_done reported while still busy");

  a_drop_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_request_dropped_r |-> out_busy_res_r)
    else $error("request dropped while idle");

  a_idle_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> bits_r == 4'd0)
    else $error("bits left while idle");

  a_bit_phase_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BIT_MARK || phase_r == PH_BIT_GAP) |-> bits_r != 4'd0)
    else $error("bit phase with no bits left");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.kind == CMD_SEND && phase_r == PH_IDLE
      |=> phase_r == PH_START_MARK && tick_r == '0 && bits_r == FRAME_BITS)
    else $error("send request did not start a frame");
`endif

endmodule

// File: rtl/core/ir_pulse_distance_transmitter.sv
// Pulse-distance IR transmitter: each input beat is either a timer tick
// (action 0) or a send request (action 1, byte in byte_value) and yields
// exactly one output beat with the carrier enable and status after that
// beat. A frame is a start mark and space, eight data bits MSB first (mark,
// then a one or zero space) and a stop mark, space and mark; durations
// come from the cfg registers and a zero duration lasts 256 ticks. Requests
// during a frame are dropped and flagged. The block takes one beat per
// clock cycle unless the output stalls: a two-entry queue feeds a sequencer
// that updates its phase and tick counter per beat, and its status goes
// into a registered output slot; while a result waits the sequencer stalls
// and input beats only fill the queue. Write cfg only while idle.
module ir_pulse_distance_transmitter
  import irpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [7:0]            in_byte_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_carrier_on,
  output logic                  out_busy_res,
  output logic                  out_frame_done,
  output logic                  out_request_dropped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_ticks        <= MARK_TICKS_RST;
      cfg_r.start_space_ticks <= START_SPACE_TICKS_RST;
      cfg_r.one_space_ticks   <= ONE_SPACE_TICKS_RST;
      cfg_r.zero_space_ticks  <= ZERO_SPACE_TICKS_RST;
      cfg_r.idle_carrier      <= IDLE_CARRIER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MARK_TICKS:        cfg_r.mark_ticks        <= cfg_data;
        CFG_START_SPACE_TICKS: cfg_r.start_space_ticks <= cfg_data;
        CFG_ONE_SPACE_TICKS:   cfg_r.one_space_ticks   <= cfg_data;
        CFG_ZERO_SPACE_TICKS:  cfg_r.zero_space_ticks  <= cfg_data;
        CFG_IDLE_CARRIER:      cfg_r.idle_carrier      <= cfg_data[0];
        default:               cfg_r                   <= cfg_r;
      endcase
    end
  end

  irpd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_cmd         (q_cmd)
  );

  irpd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_cmd               (q_cmd),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_carrier_on      (out_carrier_on),
    .out_busy_res        (out_busy_res),
    .out_frame_done      (out_frame_done),
    .out_request_dropped (out_request_dropped)
  );

endmodule

// File: tb/tb_ir_pulse_distance_transmitter.sv
module tb_ir_pulse_distance_transmitter;
  import irpd_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1050;
  localparam int unsigned PHASE_BEATS = 175;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_START_MARK,
    SEG_START_GAP,
    SEG_BIT_MARK,
    SEG_BIT_GAP,
    SEG_STOP_MARK1,
    SEG_STOP_GAP,
    SEG_STOP_MARK2
  } seg_t;

  typedef struct packed {
    logic carrier_on;
    logic busy;
    logic frame_done;
    logic dropped;
  } ir_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [7:0] in_byte_value = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_carrier_on;
  logic out_busy_res;
  logic out_frame_done;
  logic out_request_dropped;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MARK_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ir_pulse_distance_transmitter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_byte_value       (in_byte_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_carrier_on      (out_carrier_on),
    .out_busy_res        (out_busy_res),
    .out_frame_done      (out_frame_done),
    .out_request_dropped (out_request_dropped),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // transmitter state as seen by the checker
  seg_t        seg;
  logic [7:0]  seg_ticks;
  logic [7:0]  tx_shift;
  logic [3:0]  tx_bits_left;
  cfg_t        tx_cfg;

  cmd_t        pending_cmds[$];
  ir_status_t  status_due[$];
  cmd_t        drv_beat;
  logic        in_beat_taken = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  int unsigned holds_ordered = 0;
  int unsigned holds_served = 0;
  logic        send_idle_on = 1'b1;
  logic        recv_idle_on = 1'b1;
  int unsigned queued_total = 0;
  int unsigned results_seen = 0;
  int unsigned framed_beats = 0;
  int unsigned mismatches = 0;

  function automatic ir_status_t next_status(cmd_t c);
    ir_status_t r;
    logic [7:0] span;
    r = '0;
    if (c.kind == CMD_SEND) begin
      if (seg != SEG_IDLE) begin
        r.dropped = 1'b1;
      end else begin
        seg = SEG_START_MARK;
        seg_ticks = '0;
        tx_shift = c.byte_value;
        tx_bits_left = FRAME_BITS;
      end
    end else if (seg != SEG_IDLE) begin
      seg_ticks = seg_ticks + 8'd1;
      case (seg)
        SEG_START_GAP, SEG_STOP_GAP: span = tx_cfg.start_space_ticks;
        SEG_BIT_GAP: span = tx_shift[7] ? tx_cfg.one_space_ticks : tx_cfg.zero_space_ticks;
        default: span = tx_cfg.mark_ticks;
      endcase
      // a zero span is reached only after the counter wraps
      if (seg_ticks == span) begin
        seg_ticks = '0;
        case (seg)
          SEG_START_MARK: seg = SEG_START_GAP;
          SEG_START_GAP:  seg = SEG_BIT_MARK;
          SEG_BIT_MARK:   seg = SEG_BIT_GAP;
          SEG_BIT_GAP: begin
            tx_shift = tx_shift << 1;
            tx_bits_left = tx_bits_left - 4'd1;
            seg = (tx_bits_left == '0) ? SEG_STOP_MARK1 : SEG_BIT_MARK;
          end
          SEG_STOP_MARK1: seg = SEG_STOP_GAP;
          SEG_STOP_GAP:   seg = SEG_STOP_MARK2;
          default: begin
            seg = SEG_IDLE;
            r.frame_done = 1'b1;
          end
        endcase
      end
    end
    case (seg)
      SEG_IDLE: r.carrier_on = tx_cfg.idle_carrier;
      SEG_START_GAP, SEG_BIT_GAP, SEG_STOP_GAP: r.carrier_on = 1'b0;
      default: r.carrier_on = 1'b1;
    endcase
    r.busy = (seg != SEG_IDLE);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] pick_span();
    if ($urandom_range(4) != 0) return 8'($urandom_range(1, 6));
    return 8'($urandom_range(1, 48));
  endfunction

  function automatic int unsigned span_of(logic [7:0] v);
    return (v == '0) ? 256 : v;
  endfunction

  task automatic queue_beat(cmd_kind_t kind, logic [7:0] value);
    cmd_t c;
    c.kind = kind;
    c.byte_value = value;
    pending_cmds.push_back(c);
    queued_total++;
  endtask

  // send request plus exactly the ticks the frame needs, with requests
  // sprinkled in that arrive while busy
  task automatic queue_frame(logic [7:0] value, int unsigned drop_pct);
    int unsigned n;
    // start mark, eight bit marks and two stop marks; start and stop spaces
    n = 11 * span_of(tx_cfg.mark_ticks) + 2 * span_of(tx_cfg.start_space_ticks);
    for (int i = 0; i < 8; i++)
      n += value[i] ? span_of(tx_cfg.one_space_ticks) : span_of(tx_cfg.zero_space_ticks);
    queue_beat(CMD_SEND, value);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < drop_pct) queue_beat(CMD_SEND, 8'($urandom));
      queue_beat(CMD_TICK, 8'($urandom));
    end
    framed_beats += n + 1;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MARK_TICKS:        tx_cfg.mark_ticks = val;
      CFG_START_SPACE_TICKS: tx_cfg.start_space_ticks = val;
      CFG_ONE_SPACE_TICKS:   tx_cfg.one_space_ticks = val;
      CFG_ZERO_SPACE_TICKS:  tx_cfg.zero_space_ticks = val;
      CFG_IDLE_CARRIER:      tx_cfg.idle_carrier = val[0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [7:0] mark, logic [7:0] start_sp, logic [7:0] one_sp,
                            logic [7:0] zero_sp, logic [7:0] idle_lvl);
    write_reg(CFG_MARK_TICKS, mark);
    write_reg(CFG_START_SPACE_TICKS, start_sp);
    write_reg(CFG_ONE_SPACE_TICKS, one_sp);
    write_reg(CFG_ZERO_SPACE_TICKS, zero_sp);
    write_reg(CFG_IDLE_CARRIER, idle_lvl);
  endtask

  task automatic wait_drained();
    while (results_seen < queued_total) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: hold the beat until taken, then insert a gap or offer the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (send_wait > 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (send_wait > 0) send_wait--;
      end else begin
        drv_beat = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_action <= drv_beat.kind;
        in_byte_value <= drv_beat.byte_value;
        send_wait = send_idle_on ? pick_gap() : 0;
      end
    end
  end

  // receiver: random gaps plus the occasional long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_served != holds_ordered) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      out_ready <= 1'b0;
      recv_wait--;
    end else begin
      out_ready <= 1'b1;
      recv_wait = recv_idle_on ? pick_gap() : 0;
    end
  end

  // monitor: predict on every input beat, check every output beat
  always @(posedge clk) begin
    cmd_t       c;
    ir_status_t got;
    ir_status_t want;
    in_beat_taken = rst_n && in_valid && in_ready;
    if (in_beat_taken) begin
      c.kind = cmd_kind_t'(in_action);
      c.byte_value = in_byte_value;
      status_due.push_back(next_status(c));
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      got = '{out_carrier_on, out_busy_res, out_frame_done, out_request_dropped};
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: carrier_on %0b busy %0b done %0b dropped %0b",
                   got.carrier_on, got.busy, got.frame_done, got.dropped);
      end else begin
        want = status_due.pop_front();
        if (got.carrier_on !== want.carrier_on || got.busy !== want.busy ||
            got.frame_done !== want.frame_done || got.dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d exp/act carrier %0b/%0b busy %0b/%0b done %0b/%0b drop %0b/%0b",
                     results_seen, want.carrier_on, got.carrier_on, want.busy, got.busy,
                     want.frame_done, got.frame_done, want.dropped, got.dropped);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned stop_at;
    int unsigned budget;
    int unsigned phase_no;
    seg = SEG_IDLE;
    seg_ticks = '0;
    tx_shift = '0;
    tx_bits_left = '0;
    tx_cfg = '{MARK_TICKS_RST, START_SPACE_TICKS_RST, ONE_SPACE_TICKS_RST,
               ZERO_SPACE_TICKS_RST, IDLE_CARRIER_RST};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle ticks at reset values
    queue_beat(CMD_TICK, 8'hFF);
    queue_beat(CMD_TICK, 8'h00);
    wait_drained();

    // shortest segments, carrier off at rest
    set_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'hFE);
    queue_beat(CMD_TICK, 8'hA5);
    queue_frame(8'hFF, 20);
    queue_frame(8'h00, 20);
    wait_drained();

    // writes past the last register must leave the timing alone
    for (int i = CFG_IDLE_CARRIER + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), 8'($urandom));
    queue_frame(8'h5A, 0);
    queue_beat(CMD_TICK, 8'h3C);
    wait_drained();

    // longest nonzero space on the single one bit
    set_timing(8'd1, 8'd1, 8'd255, 8'd1, 8'h01);
    queue_frame(8'h80, 2);
    wait_drained();

    // zero duration wraps to 256 ticks
    set_timing(8'd1, 8'd1, 8'd1, 8'd0, 8'h00);
    queue_frame(8'hFE, 2);
    wait_drained();

    stop_at = framed_beats + RANDOM_BEATS;
    phase_no = 0;
    while (framed_beats < stop_at) begin
      set_timing(pick_span(), pick_span(), pick_span(), pick_span(), 8'($urandom));
      send_idle_on = ($urandom_range(3) != 0);
      recv_idle_on = ($urandom_range(3) != 0);
      budget = framed_beats + PHASE_BEATS;
      while (framed_beats < budget) begin
        queue_frame(8'($urandom), $urandom_range(8));
        repeat ($urandom_range(3)) queue_beat(CMD_TICK, 8'($urandom));
      end
      // stall the output while the sender keeps pushing, so the input backs up
      if (phase_no % 4 == 1) holds_ordered++;
      phase_no++;
      wait_drained();
    end

    if (mismatches == 0 && status_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
